FILE: sv/fcam_pkg.sv
// Package: payload types, constants and the CORDIC arctangent table.
`default_nettype none
package fcam_pkg;
    localparam int CORDIC_ITERATIONS_DEF = 16;
    localparam int VECTOR_FRAC_BITS_DEF = 14;
    localparam int TABLE_LEN = 24;
    localparam int ZW = 26;
    localparam int CW = 34;

    localparam logic [16:0] DEG360 = 17'd92160;
    localparam logic [16:0] DEG270 = 17'd69120;
    localparam logic [16:0] DEG180 = 17'd46080;
    localparam logic [16:0] DEG90 = 17'd23040;
    localparam logic signed [16:0] PITCH_LIM = 17'sd22784;
    localparam logic [13:0] FOV_MIN = 14'd256;
    localparam logic [13:0] FOV_MAX = 14'd11520;
    localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;
    localparam logic [15:0] SPEED_RESET = 16'd640;

    typedef enum logic [1:0] {
        CMD_TURN = 2'd0,
        CMD_MOVE = 2'd1,
        CMD_ZOOM = 2'd2,
        CMD_RESTART = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_SPEED = 2'd0,
        REG_START_X = 2'd1,
        REG_START_Y = 2'd2,
        REG_START_Z = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_MUL,
        ST_MOVE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [1:0] command;
        logic signed [15:0] horizontal_delta;
        logic signed [15:0] vertical_delta;
        logic [2:0] move_direction;
        logic [15:0] step_time;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] front_x;
        logic signed [15:0] front_y;
        logic signed [15:0] front_z;
        logic signed [15:0] up_x;
        logic signed [15:0] up_y;
        logic signed [15:0] up_z;
        logic [13:0] zoom;
    } out_word_t;

    // CORDIC lane state handed from cell to cell
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } cord_t;

    function automatic logic signed [ZW-1:0] atan_deg(input logic [4:0] i);
        logic signed [ZW-1:0] r;
        begin
            case (i)
                5'd0: r = 26'sd2949120;
                5'd1: r = 26'sd1740967;
                5'd2: r = 26'sd919879;
                5'd3: r = 26'sd466945;
                5'd4: r = 26'sd234379;
                5'd5: r = 26'sd117304;
                5'd6: r = 26'sd58666;
                5'd7: r = 26'sd29335;
                5'd8: r = 26'sd14668;
                5'd9: r = 26'sd7334;
                5'd10: r = 26'sd3667;
                5'd11: r = 26'sd1833;
                5'd12: r = 26'sd917;
                5'd13: r = 26'sd458;
                5'd14: r = 26'sd229;
                5'd15: r = 26'sd115;
                5'd16: r = 26'sd57;
                5'd17: r = 26'sd29;
                5'd18: r = 26'sd14;
                5'd19: r = 26'sd7;
                5'd20: r = 26'sd4;
                5'd21: r = 26'sd2;
                5'd22: r = 26'sd1;
                default: r = 26'sd0;
            endcase
            return r;
        end
    endfunction
endpackage
`default_nettype wire

FILE: sv/fcam_cordic_cell.sv
// One CORDIC rotation cell: fixed shift and angle, registered output.
`default_nettype none
module fcam_cordic_cell #(
    parameter int STAGE = 0
) (
    input wire logic clk,
    input wire logic advance,
    input wire fcam_pkg::cord_t din,
    output fcam_pkg::cord_t dout
);
    fcam_pkg::cord_t q_reg;
    fcam_pkg::cord_t q_next;
    localparam logic [4:0] IDX = 5'(STAGE);

    // rotate toward zero residual angle
    always_comb
    begin
        if (din.z >= 0)
        begin
            q_next.x = din.x - (din.y >>> STAGE);
            q_next.y = din.y + (din.x >>> STAGE);
            q_next.z = din.z - fcam_pkg::atan_deg(IDX);
        end
        else
        begin
            q_next.x = din.x + (din.y >>> STAGE);
            q_next.y = din.y - (din.x >>> STAGE);
            q_next.z = din.z + fcam_pkg::atan_deg(IDX);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            q_reg <= q_next;
        end
    end

    assign dout = q_reg;
endmodule
`default_nettype wire

FILE: sv/fcam_cordic_chain.sv
// Row of CORDIC cells; yaw and pitch angles travel through it back to back.
`default_nettype none
module fcam_cordic_chain #(
    parameter int CORDIC_ITERATIONS = fcam_pkg::CORDIC_ITERATIONS_DEF
) (
    input wire logic clk,
    input wire logic advance,
    input wire logic signed [fcam_pkg::ZW-1:0] angle,
    output fcam_pkg::cord_t result
);
    localparam int N = (CORDIC_ITERATIONS < fcam_pkg::TABLE_LEN) ?
        CORDIC_ITERATIONS : fcam_pkg::TABLE_LEN;
    fcam_pkg::cord_t link [N+1];

    assign link[0].x = fcam_pkg::GAIN_Q30;
    assign link[0].y = '0;
    assign link[0].z = angle;

    for (genvar g = 0; g < N; g++)
    begin : g_cell
        fcam_cordic_cell #(.STAGE(g)) u_cell (
            .clk(clk), .advance(advance), .din(link[g]), .dout(link[g+1])
        );
    end

    assign result = link[N];
endmodule
`default_nettype wire

FILE: sv/fly_camera_orientation_unit.sv
// Top level: command decode, state registers, basis and move arithmetic.
// Turn runs CORDIC, MUL, MOVE, OUT (the cell row is stepped once per cycle,
// yaw then pitch); move runs MUL, MOVE, OUT; zoom and restart only OUT.
// Throughput: one word at a time; the next is taken once the result leaves.
// Reset: asynchronous active low; state goes to the start pose, speed 640.
`default_nettype none
module fly_camera_orientation_unit #(
    parameter int CORDIC_ITERATIONS = fcam_pkg::CORDIC_ITERATIONS_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    output logic in_stall,
    input wire fcam_pkg::in_word_t in_data,
    output logic out_valid,
    input wire logic out_stall,
    output fcam_pkg::out_word_t out_data,
    input wire logic cfg_we,
    input wire logic [1:0] cfg_index,
    input wire logic [31:0] cfg_data
);
    localparam int F = fcam_pkg::VECTOR_FRAC_BITS_DEF;
    localparam int N = (CORDIC_ITERATIONS < fcam_pkg::TABLE_LEN) ?
        CORDIC_ITERATIONS : fcam_pkg::TABLE_LEN;
    localparam int CNTW = $clog2(N + 4);
    localparam logic signed [15:0] ONE = 16'sd1 <<< F;
    localparam logic signed [15:0] NONE = -(16'sd1 <<< F);
    localparam int SH = 30 - F;
    localparam int MSH = 8 + F;

    fcam_pkg::state_t state_reg, state_next;
    logic [CNTW-1:0] cnt_reg;
    logic [15:0] speed_reg;
    logic signed [31:0] start_reg [3];
    logic [16:0] yaw_reg;
    logic signed [15:0] pitch_reg;
    logic [13:0] fov_reg;
    logic signed [31:0] pos_reg [3];
    logic signed [15:0] front_reg [3];
    logic signed [15:0] right_reg [3];
    logic signed [15:0] up_reg [3];
    logic signed [15:0] cy_reg, sy_reg, cp_reg, sp_reg;
    logic negc_reg;
    fcam_pkg::in_word_t cmd_reg;
    logic signed [32:0] vel_reg;
    logic signed [47:0] prod_reg [3];
    logic signed [31:0] prod4_reg;
    logic signed [31:0] prod_v [4];

    logic accept;
    logic advance;
    logic signed [fcam_pkg::ZW-1:0] angle;
    fcam_pkg::cord_t cres;
    logic signed [15:0] c_cos, c_sin;

    assign accept = in_valid && !in_stall;
    assign in_stall = (state_reg != fcam_pkg::ST_IDLE);
    assign advance = (state_reg == fcam_pkg::ST_CORDIC);

    // fold yaw into +-90 degrees; the row takes yaw while the count is zero, pitch after
    logic [16:0] yfold;
    logic negc_w;
    always_comb
    begin
        negc_w = 1'b0;
        yfold = yaw_reg;
        if (yaw_reg > fcam_pkg::DEG90 && yaw_reg <= fcam_pkg::DEG270)
        begin
            yfold = fcam_pkg::DEG180 - yaw_reg;
            negc_w = 1'b1;
        end
        else if (yaw_reg > fcam_pkg::DEG270)
        begin
            yfold = yaw_reg - fcam_pkg::DEG360;
        end
        if (cnt_reg == '0)
            angle = {{(fcam_pkg::ZW-25){yfold[16]}}, yfold, 8'd0};
        else
            angle = {{(fcam_pkg::ZW-24){pitch_reg[15]}}, pitch_reg, 8'd0};
    end

    fcam_cordic_chain #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_chain (
        .clk(clk), .advance(advance), .angle(angle), .result(cres)
    );

    function automatic logic signed [15:0] clampv(input logic signed [fcam_pkg::CW:0] v);
        logic signed [15:0] r;
        begin
            if (v > ONE)
                r = ONE;
            else if (v < NONE)
                r = NONE;
            else
                r = v[15:0];
            return r;
        end
    endfunction

    function automatic logic signed [15:0] mulv(input logic signed [31:0] p);
        logic signed [31:0] s;
        begin
            s = (p + (32'sd1 <<< (F - 1))) >>> F;
            return clampv({{(fcam_pkg::CW-31){s[31]}}, s});
        end
    endfunction

    // round CORDIC outputs to Q1.F
    logic signed [fcam_pkg::CW:0] rx, ry;
    always_comb
    begin
        rx = ($signed({cres.x[fcam_pkg::CW-1], cres.x}) + (35'sd1 <<< (SH - 1))) >>> SH;
        ry = ($signed({cres.y[fcam_pkg::CW-1], cres.y}) + (35'sd1 <<< (SH - 1))) >>> SH;
        c_cos = clampv(rx);
        c_sin = clampv(ry);
    end

    // select move vector
    logic signed [15:0] mv [3];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (cmd_reg.move_direction < 3'd2)
                mv[i] = front_reg[i];
            else if (cmd_reg.move_direction < 3'd4)
                mv[i] = right_reg[i];
            else
                mv[i] = up_reg[i];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fcam_pkg::ST_IDLE:
                if (accept)
                begin
                    unique case (fcam_pkg::cmd_t'(in_data.command))
                        fcam_pkg::CMD_TURN: state_next = fcam_pkg::ST_CORDIC;
                        fcam_pkg::CMD_MOVE: state_next = fcam_pkg::ST_MUL;
                        default: state_next = fcam_pkg::ST_OUT;
                    endcase
                end
            fcam_pkg::ST_CORDIC:
                if (cnt_reg == CNTW'(N + 1)) state_next = fcam_pkg::ST_MUL;
            fcam_pkg::ST_MUL:
                if (cnt_reg == CNTW'(1)) state_next = fcam_pkg::ST_MOVE;
            fcam_pkg::ST_MOVE: state_next = fcam_pkg::ST_OUT;
            fcam_pkg::ST_OUT:
                if (!out_stall) state_next = fcam_pkg::ST_IDLE;
            default: state_next = fcam_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        out_valid = (state_reg == fcam_pkg::ST_OUT);
        out_data.pos_x = pos_reg[0];
        out_data.pos_y = pos_reg[1];
        out_data.pos_z = pos_reg[2];
        out_data.front_x = front_reg[0];
        out_data.front_y = front_reg[1];
        out_data.front_z = front_reg[2];
        out_data.up_x = up_reg[0];
        out_data.up_y = up_reg[1];
        out_data.up_z = up_reg[2];
        out_data.zoom = fov_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= fcam_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // products: turn uses four basis products, move three velocity products
    always_comb
    begin
        prod_v[0] = cy_reg * cp_reg;
        prod_v[1] = sy_reg * cp_reg;
        prod_v[2] = cy_reg * sp_reg;
        prod_v[3] = sy_reg * sp_reg;
    end

    logic signed [31:0] pit_sum;
    logic signed [17:0] yaw_sum;
    logic signed [17:0] fov_sum;
    always_comb
    begin
        yaw_sum = $signed({1'b0, yaw_reg}) + 18'(in_data.horizontal_delta);
        pit_sum = 32'(pitch_reg) + 32'(in_data.vertical_delta);
        fov_sum = $signed({4'b0, fov_reg}) - 18'(in_data.vertical_delta);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            speed_reg <= fcam_pkg::SPEED_RESET;
            yaw_reg <= '0;
            pitch_reg <= '0;
            fov_reg <= fcam_pkg::FOV_MAX;
            negc_reg <= 1'b0;
            cy_reg <= '0;
            sy_reg <= '0;
            cp_reg <= '0;
            sp_reg <= '0;
            vel_reg <= '0;
            prod4_reg <= '0;
            for (int i = 0; i < 3; i++)
            begin
                start_reg[i] <= '0;
                pos_reg[i] <= '0;
                prod_reg[i] <= '0;
            end
            front_reg[0] <= ONE; front_reg[1] <= '0; front_reg[2] <= '0;
            right_reg[0] <= '0; right_reg[1] <= '0; right_reg[2] <= ONE;
            up_reg[0] <= '0; up_reg[1] <= ONE; up_reg[2] <= '0;
        end
        else
        begin
            // config writes
            if (cfg_we)
            begin
                unique case (fcam_pkg::reg_idx_t'(cfg_index))
                    fcam_pkg::REG_SPEED: speed_reg <= cfg_data[15:0];
                    fcam_pkg::REG_START_X: start_reg[0] <= cfg_data;
                    fcam_pkg::REG_START_Y: start_reg[1] <= cfg_data;
                    default: start_reg[2] <= cfg_data;
                endcase
            end
            unique case (state_reg)
                fcam_pkg::ST_IDLE:
                begin
                    cnt_reg <= '0;
                    if (accept)
                    begin
                        unique case (fcam_pkg::cmd_t'(in_data.command))
                            fcam_pkg::CMD_TURN:
                            begin
                                if (yaw_sum < 0)
                                    yaw_reg <= 17'(yaw_sum + 18'sd92160);
                                else if (yaw_sum >= 18'sd92160)
                                    yaw_reg <= 17'(yaw_sum - 18'sd92160);
                                else
                                    yaw_reg <= yaw_sum[16:0];
                                if (pit_sum > 32'(fcam_pkg::PITCH_LIM))
                                    pitch_reg <= 16'(fcam_pkg::PITCH_LIM);
                                else if (pit_sum < -32'(fcam_pkg::PITCH_LIM))
                                    pitch_reg <= 16'(-fcam_pkg::PITCH_LIM);
                                else
                                    pitch_reg <= pit_sum[15:0];
                            end
                            fcam_pkg::CMD_ZOOM:
                                if (fov_sum < $signed({1'b0, fcam_pkg::FOV_MIN}))
                                    fov_reg <= fcam_pkg::FOV_MIN;
                                else if (fov_sum > $signed({1'b0, fcam_pkg::FOV_MAX}))
                                    fov_reg <= fcam_pkg::FOV_MAX;
                                else
                                    fov_reg <= fov_sum[13:0];
                            fcam_pkg::CMD_RESTART:
                            begin
                                for (int i = 0; i < 3; i++)
                                    pos_reg[i] <= start_reg[i];
                                yaw_reg <= '0;
                                pitch_reg <= '0;
                                fov_reg <= fcam_pkg::FOV_MAX;
                                front_reg[0] <= ONE; front_reg[1] <= '0;
                                front_reg[2] <= '0;
                                right_reg[0] <= '0; right_reg[1] <= '0;
                                right_reg[2] <= ONE;
                                up_reg[0] <= '0; up_reg[1] <= ONE; up_reg[2] <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                fcam_pkg::ST_CORDIC:
                begin
                    if (cnt_reg == CNTW'(N + 1))
                        cnt_reg <= '0;
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == '0)
                        negc_reg <= negc_w;
                    // yaw leaves the row in the cycle before pitch
                    if (cnt_reg == CNTW'(N))
                    begin
                        cy_reg <= negc_reg ? -c_cos : c_cos;
                        sy_reg <= c_sin;
                    end
                    if (cnt_reg == CNTW'(N + 1))
                    begin
                        cp_reg <= c_cos;
                        sp_reg <= c_sin;
                    end
                end
                fcam_pkg::ST_MUL:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == '0)
                    begin
                        vel_reg <= $signed({1'b0,
                            32'(cmd_reg.step_time) * 32'(speed_reg)});
                        prod_reg[0] <= 48'(prod_v[0]);
                        prod_reg[1] <= 48'(prod_v[1]);
                        prod_reg[2] <= 48'(prod_v[2]);
                        prod4_reg <= prod_v[3];
                    end
                    else
                    begin
                        for (int i = 0; i < 3; i++)
                            prod_reg[i] <= vel_reg * mv[i];
                        if (cmd_reg.command == fcam_pkg::CMD_TURN)
                        begin
                            front_reg[0] <= mulv(prod_reg[0][31:0]);
                            front_reg[1] <= sp_reg;
                            front_reg[2] <= mulv(prod_reg[1][31:0]);
                            right_reg[0] <= -sy_reg;
                            right_reg[1] <= '0;
                            right_reg[2] <= cy_reg;
                            up_reg[0] <= -mulv(prod_reg[2][31:0]);
                            up_reg[1] <= cp_reg;
                            up_reg[2] <= -mulv(prod4_reg);
                        end
                    end
                end
                fcam_pkg::ST_MOVE:
                begin
                    cnt_reg <= '0;
                    if (cmd_reg.command == fcam_pkg::CMD_MOVE &&
                        cmd_reg.move_direction <= 3'd5)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            logic signed [49:0] d;
                            logic signed [50:0] p;
                            d = ($signed({{2{prod_reg[i][47]}}, prod_reg[i]}) +
                                 (50'sd1 <<< (MSH - 1))) >>> MSH;
                            p = cmd_reg.move_direction[0] ?
                                51'(pos_reg[i]) - 51'(d) : 51'(pos_reg[i]) + 51'(d);
                            if (p > 51'sd2147483647)
                                pos_reg[i] <= 32'sh7fffffff;
                            else if (p < -51'sd2147483648)
                                pos_reg[i] <= 32'sh80000000;
                            else
                                pos_reg[i] <= p[31:0];
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // hold the command word
    always_ff @(posedge clk)
    begin
        if (accept)
            cmd_reg <= in_data;
    end

    // result is only offered from the output state
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> state_reg == fcam_pkg::ST_OUT)
        else $error("result offered outside output state");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid && $stable(out_data))
        else $error("stalled result changed");
    assert property (@(posedge clk) disable iff (!rst_n)
        fov_reg >= fcam_pkg::FOV_MIN && fov_reg <= fcam_pkg::FOV_MAX)
        else $error("field of view out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        yaw_reg < fcam_pkg::DEG360)
        else $error("yaw out of range");
endmodule
`default_nettype wire

FILE: verif/testbench.sv
// Testbench for the fly camera orientation unit: directed table, random words, predictor.
`default_nettype none
module testbench;
    localparam int FRAC = 14;
    localparam int ITERS = 16;
    localparam longint ONE = 64'sd1 << FRAC;
    localparam longint CYCLE_LIMIT = 400000;
    localparam int IW = $bits(fcam_pkg::in_word_t);

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    fcam_pkg::in_word_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    fcam_pkg::out_word_t out_data;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    fly_camera_orientation_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // camera state mirror
    longint cam_speed;
    longint cam_start [3];
    longint cam_yaw;
    longint cam_pitch;
    longint cam_pos [3];
    longint cam_front [3];
    longint cam_right [3];
    longint cam_up [3];
    longint cam_fov;

    fcam_pkg::out_word_t pose_queue [$];
    int errors = 0;
    longint cycles = 0;
    bit hold_off = 1'b0;

    function automatic longint fshr(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint clampl(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint vec_mul(longint a, longint b);
        return clampl(fshr(a * b + (64'sd1 << (FRAC - 1)), FRAC), -ONE, ONE);
    endfunction

    function automatic longint atan_step(int i);
        longint tbl [24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
            29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
        return tbl[i];
    endfunction

    function automatic void sin_cos(input longint angle, output longint c,
                                    output longint s);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        int sh;
        x = 652032874;
        y = 0;
        z = angle * 256;
        sh = 30 - FRAC;
        for (int i = 0; i < ITERS; i++)
        begin
            dx = fshr(y, i);
            dy = fshr(x, i);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= atan_step(i);
            end
            else
            begin
                x += dx; y -= dy; z += atan_step(i);
            end
        end
        c = clampl(fshr(x + (64'sd1 << (sh - 1)), sh), -ONE, ONE);
        s = clampl(fshr(y + (64'sd1 << (sh - 1)), sh), -ONE, ONE);
    endfunction

    function automatic void home_basis();
        cam_front = '{ONE, 0, 0};
        cam_right = '{0, 0, ONE};
        cam_up = '{0, ONE, 0};
    endfunction

    task automatic camera_init();
        cam_speed = 640;
        cam_start = '{0, 0, 0};
        cam_pos = '{0, 0, 0};
        cam_yaw = 0;
        cam_pitch = 0;
        cam_fov = 11520;
        home_basis();
    endtask

    function automatic void rebuild_basis();
        longint a;
        longint cy;
        longint sy;
        longint cp;
        longint sp;
        bit flip;
        a = cam_yaw;
        flip = 1'b0;
        if (a > 23040 && a <= 69120)
        begin
            a = 46080 - a;
            flip = 1'b1;
        end
        else if (a > 69120)
            a -= 92160;
        sin_cos(a, cy, sy);
        if (flip)
            cy = -cy;
        sin_cos(cam_pitch, cp, sp);
        cam_front = '{vec_mul(cy, cp), sp, vec_mul(sy, cp)};
        cam_right = '{-sy, 0, cy};
        cam_up = '{-vec_mul(cy, sp), cp, -vec_mul(sy, sp)};
    endfunction

    // apply one command word and return the pose it yields
    function automatic fcam_pkg::out_word_t predict_pose(fcam_pkg::in_word_t w);
        fcam_pkg::out_word_t r;
        longint vel;
        longint d;
        longint p;
        longint v [3];
        case (fcam_pkg::cmd_t'(w.command))
            fcam_pkg::CMD_TURN:
            begin
                cam_yaw += longint'(w.horizontal_delta);
                if (cam_yaw < 0)
                    cam_yaw += 92160;
                else if (cam_yaw >= 92160)
                    cam_yaw -= 92160;
                cam_pitch = clampl(cam_pitch + longint'(w.vertical_delta), -22784, 22784);
                rebuild_basis();
            end
            fcam_pkg::CMD_MOVE:
            begin
                if (w.move_direction <= 3'd5)
                begin
                    vel = longint'(w.step_time) * cam_speed;
                    for (int i = 0; i < 3; i++)
                    begin
                        if (w.move_direction < 3'd2)
                            v[i] = cam_front[i];
                        else if (w.move_direction < 3'd4)
                            v[i] = cam_right[i];
                        else
                            v[i] = cam_up[i];
                    end
                    for (int i = 0; i < 3; i++)
                    begin
                        d = fshr(vel * v[i] + (64'sd1 << (8 + FRAC - 1)), 8 + FRAC);
                        p = w.move_direction[0] ? cam_pos[i] - d : cam_pos[i] + d;
                        cam_pos[i] = clampl(p, -64'sd2147483648, 64'sd2147483647);
                    end
                end
            end
            fcam_pkg::CMD_ZOOM:
                cam_fov = clampl(cam_fov - longint'(w.vertical_delta), 256, 11520);
            default:
            begin
                cam_pos = cam_start;
                cam_yaw = 0;
                cam_pitch = 0;
                cam_fov = 11520;
                home_basis();
            end
        endcase
        r.pos_x = 32'(cam_pos[0]); r.pos_y = 32'(cam_pos[1]); r.pos_z = 32'(cam_pos[2]);
        r.front_x = 16'(cam_front[0]); r.front_y = 16'(cam_front[1]);
        r.front_z = 16'(cam_front[2]);
        r.up_x = 16'(cam_up[0]); r.up_y = 16'(cam_up[1]); r.up_z = 16'(cam_up[2]);
        r.zoom = cam_fov[13:0];
        return r;
    endfunction

    task automatic write_reg(input fcam_pkg::reg_idx_t idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == fcam_pkg::REG_SPEED)
            cam_speed = val[15:0];
        else
            cam_start[int'(idx) - 1] = longint'(signed'(val));
        @(posedge clk);
    endtask

    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 45)
            return 0;
        if (k < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // offer one word and hold it until taken
    task automatic send_word(input fcam_pkg::in_word_t w, input bit has_pose,
                             input fcam_pkg::out_word_t pose);
        fcam_pkg::out_word_t pred;
        int g;
        in_valid <= 1'b1;
        in_data <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pred = predict_pose(w);
        if (has_pose && pred !== pose)
        begin
            $error("directed pose differs from predictor for command %0d", w.command);
            errors++;
        end
        pose_queue.push_back(has_pose ? pose : pred);
        g = gap_len();
        if (g != 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pose_queue.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic fcam_pkg::in_word_t mk(fcam_pkg::cmd_t c, int hd, int vd,
                                              int dir, int dt);
        fcam_pkg::in_word_t w;
        w.command = c;
        w.horizontal_delta = 16'(hd);
        w.vertical_delta = 16'(vd);
        w.move_direction = 3'(dir);
        w.step_time = 16'(dt);
        return w;
    endfunction

    function automatic fcam_pkg::in_word_t random_word();
        fcam_pkg::in_word_t w;
        int k;
        w = fcam_pkg::in_word_t'(IW'({$urandom, $urandom}));
        k = $urandom_range(0, 99);
        if (k < 30)
            w.command = fcam_pkg::CMD_TURN;
        else if (k < 70)
            w.command = fcam_pkg::CMD_MOVE;
        else if (k < 92)
            w.command = fcam_pkg::CMD_ZOOM;
        else
            w.command = fcam_pkg::CMD_RESTART;
        // mostly modest angles so that pitch and zoom do not pin at their limits
        if ($urandom_range(0, 3) != 0)
        begin
            w.horizontal_delta = 16'($signed($urandom_range(0, 8000)) - 4000);
            w.vertical_delta = 16'($signed($urandom_range(0, 4000)) - 2000);
        end
        return w;
    endfunction

    typedef struct {
        fcam_pkg::in_word_t w;
        bit has_pose;
        fcam_pkg::out_word_t pose;
    } stim_row_t;

    // result checker and receiver stall
    always @(posedge clk)
    begin
        fcam_pkg::out_word_t exp_pose;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pose_queue.size() == 0)
            begin
                $error("pose word with none expected");
                errors++;
            end
            else
            begin
                exp_pose = pose_queue.pop_front();
                if (out_data.pos_x !== exp_pose.pos_x) begin $error("pos_x exp %0d got %0d", exp_pose.pos_x, out_data.pos_x); errors++; end
                if (out_data.pos_y !== exp_pose.pos_y) begin $error("pos_y exp %0d got %0d", exp_pose.pos_y, out_data.pos_y); errors++; end
                if (out_data.pos_z !== exp_pose.pos_z) begin $error("pos_z exp %0d got %0d", exp_pose.pos_z, out_data.pos_z); errors++; end
                if (out_data.front_x !== exp_pose.front_x) begin $error("front_x exp %0d got %0d", exp_pose.front_x, out_data.front_x); errors++; end
                if (out_data.front_y !== exp_pose.front_y) begin $error("front_y exp %0d got %0d", exp_pose.front_y, out_data.front_y); errors++; end
                if (out_data.front_z !== exp_pose.front_z) begin $error("front_z exp %0d got %0d", exp_pose.front_z, out_data.front_z); errors++; end
                if (out_data.up_x !== exp_pose.up_x) begin $error("up_x exp %0d got %0d", exp_pose.up_x, out_data.up_x); errors++; end
                if (out_data.up_y !== exp_pose.up_y) begin $error("up_y exp %0d got %0d", exp_pose.up_y, out_data.up_y); errors++; end
                if (out_data.up_z !== exp_pose.up_z) begin $error("up_z exp %0d got %0d", exp_pose.up_z, out_data.up_z); errors++; end
                if (out_data.zoom !== exp_pose.zoom) begin $error("zoom exp %0d got %0d", exp_pose.zoom, out_data.zoom); errors++; end
            end
        end
    end

    always @(posedge clk)
    begin
        int k;
        if (hold_off)
            out_stall <= 1'b1;
        else
        begin
            k = $urandom_range(0, 99);
            out_stall <= (k < 25) || (k < 28 && $urandom_range(0, 1) == 1);
        end
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        stim_row_t rows [$];
        fcam_pkg::out_word_t home;
        fcam_pkg::out_word_t pinned;
        fcam_pkg::in_word_t w;

        camera_init();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        home = '{0, 0, 0, 16'(ONE), 0, 0, 0, 16'(ONE), 0, 14'd11520};
        pinned = home;
        pinned.zoom = 14'd256;

        // directed: reset pose, limits, every direction, restart
        rows.push_back('{mk(fcam_pkg::CMD_MOVE, 0, 0, 6, 65535), 1'b1, home});
        rows.push_back('{mk(fcam_pkg::CMD_MOVE, 0, 0, 7, 0), 1'b1, home});
        rows.push_back('{mk(fcam_pkg::CMD_ZOOM, 0, 32767, 0, 0), 1'b1, pinned});
        rows.push_back('{mk(fcam_pkg::CMD_ZOOM, 0, -32768, 0, 0), 1'b1, home});
        rows.push_back('{mk(fcam_pkg::CMD_ZOOM, 0, 2560, 0, 0), 1'b0, home});
        rows.push_back('{mk(fcam_pkg::CMD_TURN, 0, 0, 0, 0), 1'b0, home});
        rows.push_back('{mk(fcam_pkg::CMD_TURN, 32767, 32767, 0, 0), 1'b0, home});
        rows.push_back('{mk(fcam_pkg::CMD_TURN, -32768, -32768, 0, 0), 1'b0, home});
        rows.push_back('{mk(fcam_pkg::CMD_TURN, -256, 0, 0, 0), 1'b0, home});
        rows.push_back('{mk(fcam_pkg::CMD_TURN, 23040, 0, 0, 0), 1'b0, home});
        rows.push_back('{mk(fcam_pkg::CMD_TURN, 23041, 11520, 0, 0), 1'b0, home});
        for (int d = 0; d < 6; d++)
            rows.push_back('{mk(fcam_pkg::CMD_MOVE, 0, 0, d, 65535), 1'b0, home});
        rows.push_back('{mk(fcam_pkg::CMD_RESTART, -1, -1, 7, 65535), 1'b1, home});
        foreach (rows[i])
            send_word(rows[i].w, rows[i].has_pose, rows[i].pose);
        drain();

        // drive position into saturation from an extreme start
        write_reg(fcam_pkg::REG_SPEED, 32'hFFFF);
        write_reg(fcam_pkg::REG_START_X, 32'h7FFF0000);
        write_reg(fcam_pkg::REG_START_Y, 32'h80000000);
        write_reg(fcam_pkg::REG_START_Z, 32'h7FFFFFFF);
        send_word(mk(fcam_pkg::CMD_RESTART, 0, 0, 0, 0), 1'b0, home);
        for (int i = 0; i < 4; i++)
            send_word(mk(fcam_pkg::CMD_MOVE, 0, 0, i, 65535), 1'b0, home);
        send_word(mk(fcam_pkg::CMD_TURN, 11520, 11520, 0, 0), 1'b0, home);
        for (int i = 0; i < 6; i++)
            send_word(mk(fcam_pkg::CMD_MOVE, 0, 0, i, 65535), 1'b0, home);
        drain();

        // random phases with differing speed and start points
        for (int phase = 0; phase < 5; phase++)
        begin
            write_reg(fcam_pkg::REG_SPEED, phase == 1 ? 32'd0 : $urandom_range(0, 65535));
            write_reg(fcam_pkg::REG_START_X, $urandom);
            write_reg(fcam_pkg::REG_START_Y, phase == 2 ? 32'h80000000 : $urandom);
            write_reg(fcam_pkg::REG_START_Z, phase == 3 ? 32'h7FFFFFFF : $urandom);
            for (int i = 0; i < 110; i++)
            begin
                if (phase == 2 && i == 20)
                begin
                    fork
                        begin
                            hold_off = 1'b1;
                            repeat (300) @(posedge clk);
                            hold_off = 1'b0;
                        end
                    join_none
                end
                w = random_word();
                send_word(w, 1'b0, home);
            end
            drain();
        end

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
`default_nettype wire

FILE: fly_camera_orientation_unit.f
sv/fcam_pkg.sv
sv/fcam_cordic_cell.sv
sv/fcam_cordic_chain.sv
sv/fly_camera_orientation_unit.sv
verif/testbench.sv
